/* rtl/assert_macros.svh */
// Assertion helpers shared by the files that check their own logic.
// Both sample on the rising edge of clk and are off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define RTLU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define RTLU_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

`endif

/* rtl/rtlu_pkg.sv */
package rtlu_pkg;

	// Width of the given and received counts.
	localparam int CNT_W = 31;
	// Width of the key on the channel.
	localparam int PKEY_W = 16;
	// Width of the net score (given minus received).
	localparam int NET_W = CNT_W + 1;

	// Operation codes carried in the mode field.
	localparam logic [1:0] MODE_UPDATE = 2'd0;
	localparam logic [1:0] MODE_APPEND = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;

	typedef struct packed {
		logic [1:0]        mode;
		logic [PKEY_W-1:0] player_key;
		logic [CNT_W-1:0]  given_count;
		logic [CNT_W-1:0]  received_count;
		logic              non_player;
		logic [3:0]        rank_index;
	} in_word_t;

	typedef struct packed {
		logic              entry_valid;
		logic [PKEY_W-1:0] out_key;
		logic [CNT_W-1:0]  out_given;
		logic [CNT_W-1:0]  out_received;
		logic [3:0]        placed_rank;
		logic              kept;
		logic [4:0]        entry_count;
	} out_word_t;

endpackage

/* rtl/rtlu_chan_if.sv */
// Input channel: one word is taken when valid and ready are both high.
interface rtlu_in_if;
	import rtlu_pkg::*;

	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Result channel, same handshake.
interface rtlu_out_if;
	import rtlu_pkg::*;

	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/rtlu_entry_mem.sv */
module rtlu_entry_mem #(
	parameter int DEPTH    = 16,
	parameter int KEY_BITS = 16,
	parameter int AW       = 4
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [KEY_BITS-1:0]       wkey,
	input  logic [rtlu_pkg::CNT_W-1:0] wgiven,
	input  logic [rtlu_pkg::CNT_W-1:0] wrecv,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [KEY_BITS-1:0]       rkey,
	output logic [rtlu_pkg::CNT_W-1:0] rgiven,
	output logic [rtlu_pkg::CNT_W-1:0] rrecv
);
	import rtlu_pkg::*;

	logic [KEY_BITS-1:0] key_mem   [DEPTH];
	logic [CNT_W-1:0]    given_mem [DEPTH];
	logic [CNT_W-1:0]    recv_mem  [DEPTH];

	// One write port and one registered read port; entries hold no reset.
	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr]   <= wkey;
			given_mem[waddr] <= wgiven;
			recv_mem[waddr]  <= wrecv;
		end
		if (re) begin
			rkey   <= key_mem[raddr];
			rgiven <= given_mem[raddr];
			rrecv  <= recv_mem[raddr];
		end
	end
endmodule

/* rtl/rtlu_net_unit.sv */
module rtlu_net_unit (
	input  logic [rtlu_pkg::CNT_W-1:0]        given,
	input  logic [rtlu_pkg::CNT_W-1:0]        recv,
	input  logic signed [rtlu_pkg::NET_W-1:0] thresh,
	output logic signed [rtlu_pkg::NET_W-1:0] net,
	output logic                              lower
);
	import rtlu_pkg::*;

	// Both counts are non-negative, so one extra bit holds the difference.
	assign net   = signed'({1'b0, given}) - signed'({1'b0, recv});
	assign lower = net < thresh;
endmodule

/* rtl/ranked_top_list_update.sv */
// Channel   Role     Handshake     Word
// item      sink     valid/ready   rtlu_pkg::in_word_t, one operation
// result    source   valid/ready   rtlu_pkg::out_word_t, one per item
//
// Every word passes through prep and finish; append, read and no-op do nothing more,
// while a ranked update adds a removal scan and then a shift pass that pushes entries
// down one rank. Both passes use the single read port of the entry memory, and the
// scan shares the one net-score unit with prep.
// Reset (arst_n low) empties the list at once; entries are never cleared.
// item.ready is high only while the sequencer is idle; a finished result sits in
// the output register, so a stalled result blocks only the end of the next word.
`include "assert_macros.svh"

module ranked_top_list_update #(
	parameter int DEPTH    = 16,
	parameter int KEY_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	rtlu_in_if.sink    item,
	rtlu_out_if.source result
);
	import rtlu_pkg::*;

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LEN_W = $clog2(DEPTH + 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PREP  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_SHIFT = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	state_t             state_q;
	in_word_t           item_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   i_q;
	logic [LEN_W-1:0]   w_q;
	logic [AW-1:0]      pos_q;
	logic [AW-1:0]      j_q;
	logic               found_q;
	logic               dv_q;
	logic               rv_q;
	logic [3:0]         placed_q;
	logic               kept_q;
	logic signed [NET_W-1:0] nn_q;
	out_word_t          out_q;
	logic               out_valid_q;

	// Entry memory controls.
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [KEY_BITS-1:0] mem_wkey;
	logic [CNT_W-1:0]    mem_wgiven;
	logic [CNT_W-1:0]    mem_wrecv;
	logic                mem_re;
	logic [AW-1:0]       mem_raddr;
	logic [KEY_BITS-1:0] rd_key;
	logic [CNT_W-1:0]    rd_given;
	logic [CNT_W-1:0]    rd_recv;

	// Shared net-score unit.
	logic [CNT_W-1:0]        nu_given;
	logic [CNT_W-1:0]        nu_recv;
	logic signed [NET_W-1:0] nu_net;
	logic                    nu_lower;

	logic [KEY_BITS-1:0] new_key;
	logic                is_update;
	logic                is_append;
	logic                is_read;
	logic                room;
	logic                rank_ok;
	logic                scan_issue;
	logic                scan_keep;
	logic                scan_done;
	logic                shift_issue;
	logic                shift_place;
	logic                out_free;
	logic                fin_load;
	logic [AW-1:0]       pos_final;
	logic [AW-1:0]       last_rank;
	out_word_t           fin_word;

	rtlu_entry_mem #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS),
		.AW       (AW)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wkey   (mem_wkey),
		.wgiven (mem_wgiven),
		.wrecv  (mem_wrecv),
		.re     (mem_re),
		.raddr  (mem_raddr),
		.rkey   (rd_key),
		.rgiven (rd_given),
		.rrecv  (rd_recv)
	);

	rtlu_net_unit u_net (
		.given  (nu_given),
		.recv   (nu_recv),
		.thresh (nn_q),
		.net    (nu_net),
		.lower  (nu_lower)
	);

	// The key is compared and stored at the configured width only.
	assign new_key   = KEY_BITS'(item_q.player_key);
	assign is_update = (item_q.mode == MODE_UPDATE) && !item_q.non_player;
	assign is_append = (item_q.mode == MODE_APPEND);
	assign is_read   = (item_q.mode == MODE_READ);
	assign room      = len_q < LEN_W'(DEPTH);
	assign rank_ok   = 32'(item_q.rank_index) < 32'(len_q);

	// Removal pass: reads run one ahead of the compacting writes.
	assign scan_issue = i_q < len_q;
	assign scan_keep  = dv_q && (rd_key != new_key);
	assign scan_done  = !scan_issue && !dv_q;

	// The new entry goes ahead of the first survivor with a lower score,
	// or at the tail when there is none.
	assign pos_final = found_q ? pos_q : w_q[AW-1:0];
	assign last_rank = (w_q < LEN_W'(DEPTH)) ? w_q[AW-1:0] : AW'(DEPTH - 1);

	// Shift pass: entries move down one rank from the tail toward the insert point.
	assign shift_issue = j_q > pos_q;
	assign shift_place = !dv_q && (j_q == pos_q);

	assign out_free = !out_valid_q || result.ready;
	assign fin_load = (state_q == ST_FIN) && out_free;

	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = '0;
		mem_wkey   = new_key;
		mem_wgiven = item_q.given_count;
		mem_wrecv  = item_q.received_count;
		mem_re     = 1'b0;
		mem_raddr  = '0;
		nu_given   = item_q.given_count;
		nu_recv    = item_q.received_count;
		unique case (state_q)
			ST_PREP: begin
				if (is_append && room) begin
					mem_we    = 1'b1;
					mem_waddr = len_q[AW-1:0];
				end
				if (is_read && rank_ok) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(item_q.rank_index);
				end
			end
			ST_SCAN: begin
				nu_given = rd_given;
				nu_recv  = rd_recv;
				if (scan_keep) begin
					mem_we     = 1'b1;
					mem_waddr  = w_q[AW-1:0];
					mem_wkey   = rd_key;
					mem_wgiven = rd_given;
					mem_wrecv  = rd_recv;
				end
				if (scan_issue) begin
					mem_re    = 1'b1;
					mem_raddr = i_q[AW-1:0];
				end
			end
			ST_SHIFT: begin
				if (dv_q) begin
					mem_we     = 1'b1;
					mem_waddr  = j_q + AW'(1);
					mem_wkey   = rd_key;
					mem_wgiven = rd_given;
					mem_wrecv  = rd_recv;
				end else if (shift_place) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q;
				end
				if (shift_issue) begin
					mem_re    = 1'b1;
					mem_raddr = j_q - AW'(1);
				end
			end
			ST_IDLE, ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// Result word; entry fields come from the read register only for a valid read.
	always_comb begin
		fin_word              = '0;
		fin_word.placed_rank  = placed_q;
		fin_word.kept         = kept_q;
		fin_word.entry_count  = 5'(len_q);
		if (is_read && rv_q) begin
			fin_word.entry_valid  = 1'b1;
			fin_word.out_key      = PKEY_W'(rd_key);
			fin_word.out_given    = rd_given;
			fin_word.out_received = rd_recv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			nn_q        <= '0;
			i_q         <= '0;
			w_q         <= '0;
			pos_q       <= '0;
			j_q         <= '0;
			found_q     <= 1'b0;
			dv_q        <= 1'b0;
			rv_q        <= 1'b0;
			placed_q    <= '0;
			kept_q      <= 1'b0;
		end else begin
			// A new word may enter the output register in the cycle the old one leaves.
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					rv_q    <= is_read && rank_ok;
					i_q     <= '0;
					w_q     <= '0;
					found_q <= 1'b0;
					dv_q    <= 1'b0;
					if (is_update) begin
						nn_q    <= nu_net;
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_FIN;
					end
					if (is_append && room) begin
						placed_q <= 4'(len_q);
						kept_q   <= 1'b1;
						len_q    <= len_q + LEN_W'(1);
					end else begin
						placed_q <= '0;
						kept_q   <= 1'b0;
					end
				end
				ST_SCAN: begin
					dv_q <= scan_issue;
					if (scan_issue) begin
						i_q <= i_q + LEN_W'(1);
					end
					if (scan_keep) begin
						w_q <= w_q + LEN_W'(1);
						if (!found_q && nu_lower) begin
							found_q <= 1'b1;
							pos_q   <= w_q[AW-1:0];
						end
					end
					if (scan_done) begin
						if (!found_q && (w_q == LEN_W'(DEPTH))) begin
							// Full list and nothing scores lower: the new entry falls off.
							len_q   <= w_q;
							state_q <= ST_FIN;
						end else begin
							pos_q    <= pos_final;
							j_q      <= last_rank;
							placed_q <= 4'(pos_final);
							kept_q   <= 1'b1;
							len_q    <= (w_q < LEN_W'(DEPTH)) ? w_q + LEN_W'(1) : w_q;
							state_q  <= ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					dv_q <= shift_issue;
					if (shift_issue) begin
						j_q <= j_q - AW'(1);
					end
					if (shift_place) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_q   <= fin_word;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_q <= item.data;
		end
	end

	assign item.ready   = (state_q == ST_IDLE);
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// A taken word keeps the input closed for at least the next cycle.
	`RTLU_ASSERT(a_busy_after_accept, item.valid && item.ready |=> !item.ready, "ready stayed high after accept")
	// Compacting writes never overtake the read that feeds them.
	`RTLU_ASSERT_IMPL(a_scan_write_behind, state_q == ST_SCAN && mem_we, w_q < i_q, "scan write ahead of read")
	// A result only appears out of the finishing step.
	`RTLU_ASSERT_IMPL(a_result_from_fin, $rose(out_valid_q), $past(state_q) == ST_FIN, "result outside finish")
	// The list never grows past its depth.
	`RTLU_ASSERT(a_len_bound, len_q <= LEN_W'(DEPTH), "list length above depth")
endmodule

/* sim/ranked_top_list_update_tb.sv */
`timescale 1ns / 100ps

module ranked_top_list_update_tb;
	import rtlu_pkg::*;

	localparam int DEPTH    = 16;
	localparam int KEY_BITS = 16;

	// The mode field has one code that the package leaves unnamed. It does nothing
	// but still returns a result word.
	localparam logic [1:0] MODE_NOP = 2'd3;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// The drain pause covers the longest ranked update with a good margin.
	localparam int DRAIN_CYCLES = 100;
	// The receiver stops taking results for this long once, while the sender keeps
	// offering words, so that the output register fills and the input stalls.
	localparam int LONG_HOLD = 400;
	// The longest honest stretch without a handshake is the long hold plus one
	// update. Random stalls at 84 percent idle stay far below the limit.
	localparam int WATCHDOG_LIMIT = 3000;

	localparam int RANDOM_PER_PHASE = 150;
	localparam int KEY_POOL = 20;

	// The scoreboard keeps its own copy of the ranked list. Every accepted item word
	// is played against that copy, and the result word it must produce is queued.
	// Each result word is checked against the oldest queued one.
	class top_list_tracker;
		logic [PKEY_W-1:0] ent_key [DEPTH];
		logic [CNT_W-1:0]  ent_given [DEPTH];
		logic [CNT_W-1:0]  ent_recv [DEPTH];
		int                length;
		out_word_t         awaited [$];
		int unsigned       fails;

		function new();
			length = 0;
			fails = 0;
		endfunction

		function logic signed [NET_W-1:0] net_at(int i);
			return $signed({1'b0, ent_given[i]}) - $signed({1'b0, ent_recv[i]});
		endfunction

		function void move_entry(int dst, int src);
			ent_key[dst]   = ent_key[src];
			ent_given[dst] = ent_given[src];
			ent_recv[dst]  = ent_recv[src];
		endfunction

		function out_word_t next_result(in_word_t w);
			out_word_t               r;
			logic signed [NET_W-1:0] new_net;
			int                      wr;
			int                      pos;
			int                      last;
			r = '0;
			new_net = $signed({1'b0, w.given_count}) - $signed({1'b0, w.received_count});
			case (w.mode)
				MODE_UPDATE: begin
					if (!w.non_player) begin
						// Drop every copy of the key, keeping the rest in order.
						wr = 0;
						for (int i = 0; i < length; i++) begin
							if (ent_key[i] != w.player_key) begin
								if (wr != i)
									move_entry(wr, i);
								wr++;
							end
						end
						length = wr;
						// The new entry goes ahead of the first strictly lower net
						// score, so older ties stay in front of it.
						pos = length;
						for (int i = length - 1; i >= 0; i--) begin
							if (net_at(i) < new_net)
								pos = i;
						end
						if (pos < DEPTH) begin
							last = (length < DEPTH) ? length : DEPTH - 1;
							for (int i = last; i > pos; i--)
								move_entry(i, i - 1);
							ent_key[pos]   = w.player_key;
							ent_given[pos] = w.given_count;
							ent_recv[pos]  = w.received_count;
							if (length < DEPTH)
								length++;
							r.placed_rank = 4'(pos);
							r.kept = 1'b1;
						end
					end
				end
				MODE_APPEND: begin
					if (length < DEPTH) begin
						ent_key[length]   = w.player_key;
						ent_given[length] = w.given_count;
						ent_recv[length]  = w.received_count;
						r.placed_rank = 4'(length);
						r.kept = 1'b1;
						length++;
					end
				end
				MODE_READ: begin
					if (w.rank_index < length) begin
						r.entry_valid  = 1'b1;
						r.out_key      = ent_key[w.rank_index];
						r.out_given    = ent_given[w.rank_index];
						r.out_received = ent_recv[w.rank_index];
					end
				end
				default: ;
			endcase
			r.entry_count = 5'(length);
			return r;
		endfunction

		function void note_item(in_word_t w);
			awaited.push_back(next_result(w));
		endfunction

		function void compare_field(string field, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
				fails++;
			end
		endfunction

		function void check_result(out_word_t got);
			out_word_t want;
			if (awaited.size() == 0) begin
				$error("result word arrived with no item word waiting for it");
				fails++;
				return;
			end
			want = awaited.pop_front();
			compare_field("entry_valid", want.entry_valid, got.entry_valid);
			compare_field("out_key", want.out_key, got.out_key);
			compare_field("out_given", want.out_given, got.out_given);
			compare_field("out_received", want.out_received, got.out_received);
			compare_field("placed_rank", want.placed_rank, got.placed_rank);
			compare_field("kept", want.kept, got.kept);
			compare_field("entry_count", want.entry_count, got.entry_count);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	rtlu_in_if  item_ch ();
	rtlu_out_if result_ch ();

	ranked_top_list_update #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	top_list_tracker board;

	// Idle rates. The sender's rate is used only by the main process. The receiver's
	// rate and the hold request are read by the receiver process, so they change
	// through nonblocking assignments at the clock edge.
	int unsigned sender_idle_pct;
	int unsigned recv_idle_pct = 84;
	logic        hold_go = 1'b0;
	int unsigned quiet_cycles = 0;

	// Random keys come mostly from a small pool, so that updates often hit a key
	// that is already listed and the list fills and evicts. The pool holds both
	// all-zero and all-one keys, so every key bit is seen both ways.
	logic [PKEY_W-1:0] key_pool [KEY_POOL];

	function automatic in_word_t make_word(logic [1:0] mode, logic [PKEY_W-1:0] key,
			logic [CNT_W-1:0] given, logic [CNT_W-1:0] received, logic non_player,
			logic [3:0] rank);
		in_word_t w;
		w.mode           = mode;
		w.player_key     = key;
		w.given_count    = given;
		w.received_count = received;
		w.non_player     = non_player;
		w.rank_index     = rank;
		return w;
	endfunction

	// Mostly small counts, so that net scores tie often; some full-width and
	// near-maximum values so every count bit toggles and the net score saturates
	// its range.
	function automatic logic [CNT_W-1:0] random_count();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 60)
			return CNT_W'($urandom_range(20));
		else if (pick < 80)
			return CNT_W'($urandom);
		else if (pick < 90)
			return CNT_MAX - CNT_W'($urandom_range(3));
		else
			return '0;
	endfunction

	function automatic in_word_t random_item();
		in_word_t    w;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 55)
			w.mode = MODE_UPDATE;
		else if (pick < 67)
			w.mode = MODE_APPEND;
		else if (pick < 95)
			w.mode = MODE_READ;
		else
			w.mode = MODE_NOP;
		if ($urandom_range(9) == 0)
			w.player_key = PKEY_W'($urandom);
		else
			w.player_key = key_pool[$urandom_range(KEY_POOL - 1)];
		w.given_count    = random_count();
		w.received_count = random_count();
		w.non_player     = ($urandom_range(9) == 0);
		w.rank_index     = 4'($urandom_range(15));
		return w;
	endfunction

	// Offer one word and return once it has been taken. Idle cycles go in front of
	// the word; when none are drawn, valid simply stays high from the last word.
	task automatic send_word(input in_word_t w);
		while ($urandom_range(99) < sender_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= w;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
	endtask

	task automatic run_directed();
		// Empty list: a read finds nothing and a non-player update is dropped.
		send_word(make_word(MODE_READ, '0, '0, '0, 1'b0, 4'd0));
		send_word(make_word(MODE_UPDATE, 16'hFFFF, CNT_MAX, '0, 1'b1, 4'd0));
		// Highest possible net score, then the lowest.
		send_word(make_word(MODE_UPDATE, 16'h0000, CNT_MAX, '0, 1'b0, 4'd0));
		send_word(make_word(MODE_UPDATE, 16'hFFFF, '0, CNT_MAX, 1'b0, 4'd0));
		// Two entries with equal net score: the second lands behind the first.
		send_word(make_word(MODE_UPDATE, 16'h0001, 31'd5, 31'd5, 1'b0, 4'd0));
		send_word(make_word(MODE_UPDATE, 16'h0002, 31'd5, 31'd5, 1'b0, 4'd0));
		// An append repeats a listed key; the next update for it removes both copies.
		send_word(make_word(MODE_APPEND, 16'h0001, 31'd7, '0, 1'b0, 4'd0));
		send_word(make_word(MODE_READ, '0, '0, '0, 1'b0, 4'd4));
		send_word(make_word(MODE_UPDATE, 16'h0001, 31'd3, '0, 1'b0, 4'd0));
		// Reading past the end, and the unused mode with every other bit set.
		send_word(make_word(MODE_READ, '0, '0, '0, 1'b0, 4'd15));
		send_word(make_word(MODE_NOP, 16'hFFFF, CNT_MAX, CNT_MAX, 1'b1, 4'd15));
		// The top entry comes back with both counts at their maximum.
		send_word(make_word(MODE_UPDATE, 16'h0000, CNT_MAX, CNT_MAX, 1'b0, 4'd0));
		// Four entries are listed now; twelve appends fill the list and the
		// thirteenth is turned away.
		for (int i = 0; i < 13; i++)
			send_word(make_word(MODE_APPEND, PKEY_W'(16'h0100 + i), random_count(),
				random_count(), 1'b0, 4'd0));
		// On a full list an update with the lowest possible score is not kept, while
		// a high score pushes the last entry out.
		send_word(make_word(MODE_UPDATE, 16'h0BAD, '0, CNT_MAX, 1'b0, 4'd0));
		send_word(make_word(MODE_UPDATE, 16'h0ACE, CNT_MAX - 31'd1, '0, 1'b0, 4'd0));
		send_word(make_word(MODE_READ, '0, '0, '0, 1'b0, 4'd15));
	endtask

	// Receiver: ready is redrawn every cycle from the current idle rate. Once the
	// hold request is seen, ready stays low for a long counted stretch.
	initial begin
		logic held;
		held = 1'b0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !held) begin
				held = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD)
					@(posedge clk);
			end
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Both channels are sampled at the rising edge, before any nonblocking update
	// of that edge lands. A result is checked before the item word of the same
	// edge is noted; the two can never belong to each other.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready)
				board.check_result(result_ch.data);
			if (item_ch.valid && item_ch.ready)
				board.note_item(item_ch.data);
		end
	end

	// Watchdog: too many cycles in a row without a handshake on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		// Driven as an update so that the falling reset edge reaches the block.
		arst_n        <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.data  <= '0;
		board = new();
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < KEY_POOL; i++)
			key_pool[i] = PKEY_W'($urandom);

		// First phase: the sender idles now and then, the receiver most of the time.
		sender_idle_pct = 37;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		repeat (RANDOM_PER_PHASE)
			send_word(random_item());

		// Second phase: the rates swap.
		sender_idle_pct = 84;
		recv_idle_pct <= 37;
		repeat (RANDOM_PER_PHASE)
			send_word(random_item());

		// Last phase: nobody idles, apart from one long receiver hold at its start
		// while the sender keeps pushing words at the block.
		sender_idle_pct = 0;
		recv_idle_pct <= 0;
		hold_go <= 1'b1;
		repeat (RANDOM_PER_PHASE)
			send_word(random_item());
		item_ch.valid <= 1'b0;

		while (board.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (board.fails == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
